// File: src/abma_pkg.sv
package abma_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Fixed field widths
    localparam int BCNT_W    = 7;
    localparam int CFG_LEN_W = 24;
    localparam int IDX_W     = 6;
    localparam int FRAC_BITS = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUCKET_COUNT   = 2'd0,
        CFG_WINDOW_LENGTH  = 2'd1,
        CFG_STEREO         = 2'd2,
        CFG_SPLIT_CHANNELS = 2'd3
    } t_cfg_reg;

endpackage

// File: src/abma_frame_if.sv
interface abma_frame_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_left;
    logic signed [SAMPLE_BITS-1:0] sample_right;

    modport source (output valid, output sample_left, output sample_right, input ready);
    modport sink (input valid, input sample_left, input sample_right, output ready);
endinterface

// File: src/abma_result_if.sv
interface abma_result_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic [abma_pkg::IDX_W-1:0]    bucket_index;
    logic [SAMPLE_BITS+abma_pkg::FRAC_BITS-1:0] amplitude_main;
    logic [SAMPLE_BITS+abma_pkg::FRAC_BITS-1:0] amplitude_second;
    logic                          bucket_empty;
    logic                          window_done;

    modport source (
        output valid, output bucket_index, output amplitude_main,
        output amplitude_second, output bucket_empty, output window_done,
        input ready
    );
    modport sink (
        input valid, input bucket_index, input amplitude_main,
        input amplitude_second, input bucket_empty, input window_done,
        output ready
    );
endinterface

// File: src/abma_div.sv
module abma_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 25
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot,
    output logic [DEN_W-1:0] o_rem
);
    localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   n_trial;
    logic [DEN_W:0]   n_diff;
    logic             n_ge;
    logic [DEN_W-1:0] n_rem;

    // One quotient bit per cycle: the numerator shifts out of r_q at the top
    // while quotient bits shift in at the bottom.
    always_comb begin
        n_trial = {r_rem, r_q[NUM_W-1]};
        n_diff  = n_trial - {1'b0, r_den};
        n_ge    = (n_trial >= {1'b0, r_den});
        n_rem   = n_ge ? n_diff[DEN_W-1:0] : n_trial[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_q   <= {r_q[NUM_W-2:0], n_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done held for more than one cycle");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && (r_den != '0)) |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");
`endif
endmodule

// File: src/audio_bucket_mean_amplitude.sv
// Bucketed mean absolute amplitude of an audio window. Each accepted word is
// one mono or stereo frame; a window of window_length frames is split into
// bucket_count buckets, the first (length mod buckets) holding one frame more,
// and each bucket yields one result word with its mean in unsigned 16.8 fixed
// point. All divisions go through one shared restoring divider that produces
// one quotient bit per cycle over SAMPLE_BITS + min(WINDOW_BITS, 24) + 8 steps
// (48 with the default parameters). A frame that does not close a bucket
// passes through S_ACC and S_CHK back to S_IDLE; the first frame of a window
// adds one division for the bucket sizes; a frame that closes a bucket adds
// one division, or two in split stereo mode, and then waits until its result
// word is taken. When the window has fewer frames than buckets, the empty
// buckets follow the last frame at one result word a cycle while the receiver
// is ready. The input is not ready while a frame is being worked on. Writing
// any configuration register abandons the window in progress.
module audio_bucket_mean_amplitude #(
    parameter int MAX_BUCKETS = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int WINDOW_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    abma_frame_if.sink                          i_frame,
    abma_result_if.source                       o_result,
    input  logic                                i_cfg_we,
    input  logic [abma_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [abma_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import abma_pkg::*;

    localparam int LEN_W = (WINDOW_BITS < CFG_LEN_W) ? WINDOW_BITS : CFG_LEN_W;
    localparam int SUM_W = SAMPLE_BITS + LEN_W;
    localparam int NUM_W = SUM_W + FRAC_BITS;
    localparam int DEN_W = LEN_W + 1;
    localparam int AMP_W = SAMPLE_BITS + FRAC_BITS;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_WDIV  = 8'b0000_0010,
        S_ACC   = 8'b0000_0100,
        S_CHK   = 8'b0000_1000,
        S_DIV1  = 8'b0001_0000,
        S_DIV2  = 8'b0010_0000,
        S_OUT   = 8'b0100_0000,
        S_EMPTY = 8'b1000_0000
    } t_state;

    // Configuration
    logic [BCNT_W-1:0] r_bucket_count;
    logic [LEN_W-1:0]  r_window_length;
    logic              r_stereo;
    logic              r_split;

    // Progress
    t_state            r_state;
    logic [LEN_W-1:0]  r_frames;
    logic [BCNT_W-1:0] r_cur;
    logic [SUM_W-1:0]  r_sum_first;
    logic [SUM_W-1:0]  r_sum_second;
    logic [LEN_W-1:0]  r_base;
    logic [BCNT_W-1:0] r_long;
    logic [SAMPLE_BITS-1:0] r_a0;
    logic [SAMPLE_BITS-1:0] r_a1;
    logic [AMP_W-1:0]  r_mean_main;
    logic [AMP_W-1:0]  r_mean_second;

    logic [BCNT_W-1:0] n_nb;
    logic [LEN_W-1:0]  n_len;
    logic              n_combined;
    logic              n_win_start;
    logic [SAMPLE_BITS-1:0] n_abs_left;
    logic [SAMPLE_BITS-1:0] n_abs_right;
    logic [LEN_W:0]    n_size;
    logic              n_bucket_end;
    logic              n_last;
    logic [BCNT_W-1:0] n_long_dec;
    logic              in_accept;
    logic              out_accept;

    logic              div_start;
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic              div_done;
    logic [NUM_W-1:0]  div_quot;
    logic [DEN_W-1:0]  div_rem;

    always_comb begin
        if (r_bucket_count == '0) begin
            n_nb = BCNT_W'(1);
        end else if (r_bucket_count > BCNT_W'(MAX_BUCKETS)) begin
            n_nb = BCNT_W'(MAX_BUCKETS);
        end else begin
            n_nb = r_bucket_count;
        end
        n_len        = (r_window_length == '0) ? LEN_W'(1) : r_window_length;
        n_combined   = r_stereo && !r_split;
        n_win_start  = (r_cur == '0) && (r_frames == '0);
        n_abs_left   = i_frame.sample_left[SAMPLE_BITS-1] ?
                       SAMPLE_BITS'(~i_frame.sample_left) + SAMPLE_BITS'(1) :
                       SAMPLE_BITS'(i_frame.sample_left);
        n_abs_right  = i_frame.sample_right[SAMPLE_BITS-1] ?
                       SAMPLE_BITS'(~i_frame.sample_right) + SAMPLE_BITS'(1) :
                       SAMPLE_BITS'(i_frame.sample_right);
        n_size       = {1'b0, r_base} + ((r_long != '0) ? (LEN_W+1)'(1) : '0);
        n_bucket_end = ({1'b0, r_frames} >= n_size);
        n_last       = (({1'b0, r_cur} + 8'd1) >= {1'b0, n_nb});
        n_long_dec   = (r_long != '0) ? (r_long - BCNT_W'(1)) : '0;
        in_accept    = i_frame.valid && i_frame.ready;
        out_accept   = o_result.valid && o_result.ready;
    end

    // Divider operand selection: bucket sizes at window start, then the means.
    always_comb begin
        div_start = 1'b0;
        div_num   = {r_sum_first, FRAC_BITS'(0)};
        div_den   = n_combined ? {r_frames, 1'b0} : DEN_W'(r_frames);
        case (r_state)
            S_IDLE: begin
                div_start = in_accept && n_win_start;
                div_num   = NUM_W'(n_len);
                div_den   = DEN_W'(n_nb);
            end
            S_CHK: begin
                div_start = n_bucket_end;
            end
            S_DIV1: begin
                div_start = div_done && r_stereo && r_split;
                div_num   = {r_sum_second, FRAC_BITS'(0)};
                div_den   = DEN_W'(r_frames);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    abma_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count  <= BCNT_W'(1);
            r_window_length <= LEN_W'(1);
            r_stereo        <= 1'b0;
            r_split         <= 1'b0;
            r_state         <= S_IDLE;
            r_frames        <= '0;
            r_cur           <= '0;
            r_sum_first     <= '0;
            r_sum_second    <= '0;
            r_base          <= '0;
            r_long          <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BUCKET_COUNT:   r_bucket_count  <= i_cfg_data[BCNT_W-1:0];
                CFG_WINDOW_LENGTH:  r_window_length <= i_cfg_data[LEN_W-1:0];
                CFG_STEREO:         r_stereo        <= i_cfg_data[0];
                CFG_SPLIT_CHANNELS: r_split         <= i_cfg_data[0];
                default:            r_stereo        <= r_stereo;
            endcase
            r_state      <= S_IDLE;
            r_frames     <= '0;
            r_cur        <= '0;
            r_sum_first  <= '0;
            r_sum_second <= '0;
            r_base       <= '0;
            r_long       <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_a0    <= n_abs_left;
                        r_a1    <= r_stereo ? n_abs_right : '0;
                        r_state <= n_win_start ? S_WDIV : S_ACC;
                    end
                end
                S_WDIV: begin
                    if (div_done) begin
                        r_base       <= div_quot[LEN_W-1:0];
                        r_long       <= div_rem[BCNT_W-1:0];
                        r_sum_first  <= '0;
                        r_sum_second <= '0;
                        r_state      <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (n_combined) begin
                        r_sum_first <= r_sum_first + SUM_W'(r_a0) + SUM_W'(r_a1);
                    end else begin
                        r_sum_first  <= r_sum_first + SUM_W'(r_a0);
                        r_sum_second <= r_sum_second + SUM_W'(r_a1);
                    end
                    r_frames <= r_frames + LEN_W'(1);
                    r_state  <= S_CHK;
                end
                S_CHK: begin
                    r_state <= n_bucket_end ? S_DIV1 : S_IDLE;
                end
                S_DIV1: begin
                    if (div_done) begin
                        r_mean_main <= div_quot[AMP_W-1:0];
                        if (r_stereo && r_split) begin
                            r_state <= S_DIV2;
                        end else begin
                            r_mean_second <= '0;
                            r_state       <= S_OUT;
                        end
                    end
                end
                S_DIV2: begin
                    if (div_done) begin
                        r_mean_second <= div_quot[AMP_W-1:0];
                        r_state       <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_accept) begin
                        r_sum_first  <= '0;
                        r_sum_second <= '0;
                        r_frames     <= '0;
                        if (n_last) begin
                            r_cur   <= '0;
                            r_base  <= '0;
                            r_long  <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_cur  <= r_cur + BCNT_W'(1);
                            r_long <= n_long_dec;
                            // Fewer frames than buckets: the rest of the
                            // window is empty buckets, sent straight away.
                            if ((r_base == '0) && (n_long_dec == '0)) begin
                                r_mean_main   <= '0;
                                r_mean_second <= '0;
                                r_state       <= S_EMPTY;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end
                S_EMPTY: begin
                    if (out_accept) begin
                        if (n_last) begin
                            r_cur   <= '0;
                            r_base  <= '0;
                            r_long  <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_cur <= r_cur + BCNT_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_frame.ready             = (r_state == S_IDLE);
    assign o_result.valid            = (r_state == S_OUT) || (r_state == S_EMPTY);
    assign o_result.bucket_index     = r_cur[IDX_W-1:0];
    assign o_result.amplitude_main   = r_mean_main;
    assign o_result.amplitude_second = r_mean_second;
    assign o_result.bucket_empty     = (r_state == S_EMPTY);
    assign o_result.window_done      = n_last;

`ifndef ASSERT_OFF
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_frame.ready |-> !o_result.valid)
        else $error("input ready while a result word is pending");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (r_cur < n_nb))
        else $error("bucket index beyond bucket count");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.bucket_empty) |->
        ((o_result.amplitude_main == '0) && (o_result.amplitude_second == '0)))
        else $error("empty bucket with non-zero amplitude");

    a_window_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_accept && o_result.window_done && !i_cfg_we) |=>
        ((r_cur == '0) && (r_frames == '0) && (r_state == S_IDLE)))
        else $error("progress not cleared after last bucket");

    a_frames_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV1) |-> (r_frames != '0))
        else $error("mean division over zero frames");
`endif
endmodule

// File: test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import abma_pkg::*;

    localparam int BUCKET_LIMIT = 64;
    localparam int SETTLE_CYCLES = 160;
    localparam int DRAIN_LIMIT = 200000;
    localparam int RANDOM_FRAMES = 500;

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
    } t_frame_word;

    typedef struct {
        logic [IDX_W-1:0] bucket_index;
        logic [23:0]      amp_main;
        logic [23:0]      amp_second;
        logic             empty;
        logic             done;
    } t_bucket_mean;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    abma_frame_if #(.SAMPLE_BITS(16)) frame_bus ();
    abma_result_if #(.SAMPLE_BITS(16)) result_bus ();

    audio_bucket_mean_amplitude #(
        .MAX_BUCKETS(64),
        .SAMPLE_BITS(16),
        .WINDOW_BITS(24)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_frame     (frame_bus),
        .o_result    (result_bus),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Registers and window progress as the block should hold them.
    logic [6:0]  cfg_buckets;
    logic [23:0] cfg_length;
    logic        cfg_stereo;
    logic        cfg_split;
    logic [23:0] frames_in_bucket;
    logic [6:0]  bucket_no;
    logic [39:0] sum_main;
    logic [39:0] sum_second;
    logic [23:0] base_size;
    logic [6:0]  long_left;

    t_bucket_mean pending_means[$];
    t_frame_word  frame_queue[$];
    t_frame_word  next_frame;

    int sender_idle_pct;
    int receiver_idle_pct;
    int frames_queued;
    int frames_sent = 0;
    int frames_accepted = 0;
    int results_checked = 0;
    int windows_closed = 0;
    int mismatches = 0;
    int phases_run;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int unsigned active_buckets();
        if (cfg_buckets == 7'd0) return 1;
        if (cfg_buckets > BUCKET_LIMIT) return BUCKET_LIMIT;
        return cfg_buckets;
    endfunction

    function automatic int unsigned active_length();
        return (cfg_length == 24'd0) ? 1 : cfg_length;
    endfunction

    function automatic logic [16:0] magnitude(logic signed [15:0] s);
        logic [16:0] v;
        v = {s[15], s};
        if (s[15]) v = -v;
        return v;
    endfunction

    // floor(256 * total / count), split so that nothing overflows.
    function automatic logic [23:0] mean_q8(logic [63:0] total, logic [63:0] count);
        logic [63:0] whole;
        logic [63:0] rest;
        logic [63:0] scaled;
        if (count == 64'd0) return 24'd0;
        whole = total / count;
        rest = total % count;
        scaled = (whole << 8) + ((rest << 8) / count);
        return scaled[23:0];
    endfunction

    function automatic logic signed [15:0] random_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sd0;
            3: return -16'sd1;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic clear_progress();
        frames_in_bucket = '0;
        bucket_no = '0;
        sum_main = '0;
        sum_second = '0;
        base_size = '0;
        long_left = '0;
    endtask

    task automatic apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_BUCKET_COUNT:   cfg_buckets = value[6:0];
            CFG_WINDOW_LENGTH:  cfg_length = value[23:0];
            CFG_STEREO:         cfg_stereo = value[0];
            CFG_SPLIT_CHANNELS: cfg_split = value[0];
            default: return;
        endcase
        clear_progress();
    endtask

    task automatic accumulate_frame(logic signed [15:0] left, logic signed [15:0] right);
        int unsigned  nb;
        logic [16:0]  mag_l;
        logic [16:0]  mag_r;
        logic [24:0]  bucket_size;
        logic [63:0]  sample_count;
        t_bucket_mean res;
        bit           closes_window;
        int           emitted;
        nb = active_buckets();
        if (bucket_no == 7'd0 && frames_in_bucket == 24'd0) begin
            base_size = 24'(active_length() / nb);
            long_left = 7'(active_length() % nb);
            sum_main = '0;
            sum_second = '0;
        end
        mag_l = magnitude(left);
        mag_r = cfg_stereo ? magnitude(right) : 17'd0;
        if (cfg_stereo && !cfg_split) begin
            sum_main += mag_l + mag_r;
        end else begin
            sum_main += mag_l;
            sum_second += mag_r;
        end
        frames_in_bucket++;
        bucket_size = base_size + ((long_left != 7'd0) ? 25'd1 : 25'd0);
        if (frames_in_bucket < bucket_size) return;

        sample_count = frames_in_bucket;
        res.bucket_index = bucket_no[IDX_W-1:0];
        res.amp_main = mean_q8(sum_main,
                               (cfg_stereo && !cfg_split) ? sample_count << 1 : sample_count);
        res.amp_second = (cfg_stereo && cfg_split) ? mean_q8(sum_second, sample_count) : 24'd0;
        res.empty = 1'b0;
        closes_window = (bucket_no + 1 >= nb);
        res.done = closes_window;
        pending_means.push_back(res);
        emitted = 1;

        if (long_left != 7'd0) long_left--;
        sum_main = '0;
        sum_second = '0;
        frames_in_bucket = '0;
        bucket_no++;

        // Fewer frames than buckets: the rest of the window is empty buckets.
        if (!closes_window && base_size == 24'd0 && long_left == 7'd0) begin
            while (bucket_no < nb && emitted < BUCKET_LIMIT) begin
                res.bucket_index = bucket_no[IDX_W-1:0];
                res.amp_main = 24'd0;
                res.amp_second = 24'd0;
                res.empty = 1'b1;
                res.done = (bucket_no + 1 >= nb);
                pending_means.push_back(res);
                emitted++;
                bucket_no++;
            end
            closes_window = 1'b1;
        end
        if (closes_window) clear_progress();
    endtask

    task automatic report_mismatch(string what);
        $display("%0t tb_top: mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic queue_frame(logic signed [15:0] left, logic signed [15:0] right);
        t_frame_word w;
        w.left = left;
        w.right = right;
        frame_queue.push_back(w);
        frames_queued++;
    endtask

    // Writes the registers picked by the mask, one per cycle, in list order.
    task automatic configure(logic [6:0] buckets, logic [23:0] length, bit stereo_on,
                             bit split_on, logic [3:0] which);
        if (which[0]) begin
            @(negedge i_clk);
            cfg_we <= 1'b1;
            cfg_index <= CFG_BUCKET_COUNT;
            cfg_data <= {17'd0, buckets};
            @(posedge i_clk);
        end
        if (which[1]) begin
            @(negedge i_clk);
            cfg_we <= 1'b1;
            cfg_index <= CFG_WINDOW_LENGTH;
            cfg_data <= length;
            @(posedge i_clk);
        end
        if (which[2]) begin
            @(negedge i_clk);
            cfg_we <= 1'b1;
            cfg_index <= CFG_STEREO;
            cfg_data <= {23'd0, stereo_on};
            @(posedge i_clk);
        end
        if (which[3]) begin
            @(negedge i_clk);
            cfg_we <= 1'b1;
            cfg_index <= CFG_SPLIT_CHANNELS;
            cfg_data <= {23'd0, split_on};
            @(posedge i_clk);
        end
        @(negedge i_clk);
        cfg_we <= 1'b0;
        phases_run++;
    endtask

    // Waits until every queued frame is taken and every expected word has come,
    // then gives the block time to finish a frame that closes no bucket.
    task automatic wait_until_drained();
        int waited;
        waited = 0;
        while ((frames_accepted != frames_queued || pending_means.size() != 0)
               && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (waited >= DRAIN_LIMIT) begin
            report_mismatch($sformatf("stalled with %0d frames unsent, %0d words missing",
                                      frames_queued - frames_accepted, pending_means.size()));
            pending_means.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // A new word goes out once every word sent so far has been taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            frame_bus.valid <= 1'b0;
        end else if (frames_accepted == frames_sent) begin
            if (frame_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                next_frame = frame_queue.pop_front();
                frame_bus.sample_left <= next_frame.left;
                frame_bus.sample_right <= next_frame.right;
                frame_bus.valid <= 1'b1;
                frames_sent++;
            end else begin
                frame_bus.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        result_bus.ready <= i_rst_n && ($urandom_range(0, 99) >= receiver_idle_pct);
    end

    always @(posedge i_clk) begin
        t_bucket_mean want;
        if (!i_rst_n) begin
            cfg_buckets = 7'd1;
            cfg_length = 24'd1;
            cfg_stereo = 1'b0;
            cfg_split = 1'b0;
            clear_progress();
        end else begin
            if (cfg_we) apply_register(cfg_index, cfg_data);
            if (frame_bus.valid && frame_bus.ready) begin
                accumulate_frame(frame_bus.sample_left, frame_bus.sample_right);
                frames_accepted++;
            end
            if (result_bus.valid && result_bus.ready) begin
                if (pending_means.size() == 0) begin
                    report_mismatch($sformatf("unexpected word for bucket %0d",
                                              result_bus.bucket_index));
                end else begin
                    want = pending_means.pop_front();
                    results_checked++;
                    if (want.done) windows_closed++;
                    if (result_bus.bucket_index !== want.bucket_index)
                        report_mismatch($sformatf("bucket_index %0d, expected %0d",
                                                  result_bus.bucket_index, want.bucket_index));
                    if (result_bus.amplitude_main !== want.amp_main)
                        report_mismatch($sformatf("bucket %0d amplitude_main %h, expected %h",
                                                  want.bucket_index, result_bus.amplitude_main,
                                                  want.amp_main));
                    if (result_bus.amplitude_second !== want.amp_second)
                        report_mismatch($sformatf("bucket %0d amplitude_second %h, expected %h",
                                                  want.bucket_index,
                                                  result_bus.amplitude_second, want.amp_second));
                    if (result_bus.bucket_empty !== want.empty)
                        report_mismatch($sformatf("bucket %0d bucket_empty %b, expected %b",
                                                  want.bucket_index, result_bus.bucket_empty,
                                                  want.empty));
                    if (result_bus.window_done !== want.done)
                        report_mismatch($sformatf("bucket %0d window_done %b, expected %b",
                                                  want.bucket_index, result_bus.window_done,
                                                  want.done));
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        int          random_frames;
        int          frames;
        int unsigned nb_pick;
        int unsigned len_now;
        logic [6:0]  buckets_pick;
        logic [23:0] length_pick;
        t_idle_mode  mode;

        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_BUCKET_COUNT;
        cfg_data = '0;
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        frames_queued = 0;
        phases_run = 0;
        random_frames = 0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Register values straight out of reset: one mono frame per window.
        queue_frame(16'sh7FFF, 16'sd0);
        queue_frame(16'sh8000, 16'sd7);
        queue_frame(16'sd0, 16'sd0);
        queue_frame(-16'sd1, -16'sd1);
        queue_frame(16'sd1, 16'sh7FFF);
        wait_until_drained();

        // Zero bucket count and zero length both act as one; split stereo.
        configure(7'd0, 24'd0, 1'b1, 1'b1, 4'b1111);
        queue_frame(16'sh7FFF, 16'sh8000);
        queue_frame(16'sh8000, -16'sd1);
        wait_until_drained();

        // Combined stereo with more buckets than frames, so two empty buckets follow.
        configure(7'd4, 24'd2, 1'b1, 1'b0, 4'b1111);
        queue_frame(16'sh8000, 16'sh8000);
        queue_frame(16'sh7FFF, 16'sd1);
        wait_until_drained();

        // Bucket count above the limit, mono with a right sample that must be ignored.
        configure(7'd127, 24'd3, 1'b0, 1'b0, 4'b0111);
        queue_frame(16'sd100, 16'sh8000);
        queue_frame(-16'sd200, 16'sh7FFF);
        queue_frame(16'sh7FFF, -16'sd5);
        wait_until_drained();

        // Longest window: a few frames, then the next write abandons it.
        configure(7'd65, 24'hFFFFFF, 1'b0, 1'b0, 4'b0011);
        repeat (3) queue_frame(random_sample(), random_sample());
        wait_until_drained();

        // Uneven buckets of 4, 3 and 3 frames; the sender stops halfway until
        // every word so far has come.
        configure(7'd3, 24'd10, 1'b1, 1'b1, 4'b1111);
        repeat (5) queue_frame(random_sample(), random_sample());
        wait_until_drained();
        repeat (5) queue_frame(random_sample(), random_sample());
        wait_until_drained();

        while (random_frames < RANDOM_FRAMES) begin
            mode = t_idle_mode'(phases_run % 4);
            case (mode)
                IDLE_NONE: begin
                    sender_idle_pct = 0;
                    receiver_idle_pct = 0;
                end
                IDLE_SENDER: begin
                    sender_idle_pct = 73;
                    receiver_idle_pct = 0;
                end
                IDLE_RECEIVER: begin
                    sender_idle_pct = 0;
                    receiver_idle_pct = 73;
                end
                default: begin
                    sender_idle_pct = 23;
                    receiver_idle_pct = 23;
                end
            endcase

            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 3))
                    0: buckets_pick = 7'd0;
                    1: buckets_pick = 7'd64;
                    2: buckets_pick = 7'd127;
                    default: buckets_pick = 7'($urandom_range(65, 127));
                endcase
            end else begin
                buckets_pick = 7'($urandom_range(1, 12));
            end
            nb_pick = (buckets_pick == 7'd0) ? 1 : (buckets_pick > BUCKET_LIMIT) ?
                      BUCKET_LIMIT : buckets_pick;
            case ($urandom_range(0, 9))
                0: length_pick = 24'd0;
                1: length_pick = 24'($urandom_range(1, (nb_pick > 1) ? nb_pick - 1 : 1));
                2: length_pick = ($urandom_range(0, 1) != 0) ? 24'hFFFFFF :
                                 24'h800000 | 24'($urandom);
                default: length_pick = 24'($urandom_range(1, 60));
            endcase
            configure(buckets_pick, length_pick, 1'($urandom), 1'($urandom),
                      4'($urandom_range(1, 15)));

            // Mostly whole windows; sometimes a tail that the next write cuts off.
            len_now = active_length();
            if (len_now > 200) begin
                frames = $urandom_range(1, 20);
            end else begin
                frames = $urandom_range(1, 3) * len_now;
                if ($urandom_range(0, 3) == 0) frames += $urandom_range(1, len_now);
            end
            if (frames > RANDOM_FRAMES - random_frames) frames = RANDOM_FRAMES - random_frames;
            repeat (frames) queue_frame(random_sample(), random_sample());
            random_frames += frames;
            wait_until_drained();
        end

        $display("tb_top: %0d frames over %0d register settings, %0d bucket words checked",
                 frames_accepted, phases_run, results_checked);
        $display("tb_top: %0d windows closed, mono and both stereo modes, four idle patterns",
                 windows_closed);
        if (mismatches == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
